// ----- sv/ebca_pkg.sv -----
// ---------------------------------------------------------------------------
// ebca_pkg: shared types and codes of the 8-bit CPU ALU
// Operation codes and the packed input and result beat types.
// ---------------------------------------------------------------------------
package ebca_pkg;

  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_ADC  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_SBC  = 5'd3;
  localparam logic [4:0] OP_AND  = 5'd4;
  localparam logic [4:0] OP_XOR  = 5'd5;
  localparam logic [4:0] OP_OR   = 5'd6;
  localparam logic [4:0] OP_CP   = 5'd7;
  localparam logic [4:0] OP_INC  = 5'd8;
  localparam logic [4:0] OP_DEC  = 5'd9;
  localparam logic [4:0] OP_RLCA = 5'd10;
  localparam logic [4:0] OP_RRCA = 5'd11;
  localparam logic [4:0] OP_RLA  = 5'd12;
  localparam logic [4:0] OP_RRA  = 5'd13;
  localparam logic [4:0] OP_DAA  = 5'd14;
  localparam logic [4:0] OP_CPL  = 5'd15;
  localparam logic [4:0] OP_SCF  = 5'd16;
  localparam logic [4:0] OP_CCF  = 5'd17;
  localparam logic [4:0] OP_RLC  = 5'd18;
  localparam logic [4:0] OP_RRC  = 5'd19;
  localparam logic [4:0] OP_RL   = 5'd20;
  localparam logic [4:0] OP_RR   = 5'd21;
  localparam logic [4:0] OP_SLA  = 5'd22;
  localparam logic [4:0] OP_SRA  = 5'd23;
  localparam logic [4:0] OP_SWAP = 5'd24;
  localparam logic [4:0] OP_SRL  = 5'd25;
  localparam logic [4:0] OP_BIT  = 5'd26;
  localparam logic [4:0] OP_RES  = 5'd27;
  localparam logic [4:0] OP_SET  = 5'd28;

  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_MAX = 8'h99;
  localparam logic [3:0] DAA_LO_MAX = 4'h9;

  typedef struct packed {
    logic [4:0] operation;
    logic [7:0] first_operand;
    logic [7:0] second_operand;
    logic [2:0] bit_index;
    logic       zero_in;
    logic       subtract_in;
    logic       half_in;
    logic       carry_in;
  } in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       write_result;
    logic       zero_out;
    logic       subtract_out;
    logic       half_out;
    logic       carry_out;
  } out_t;

endpackage

// ----- sv/eight_bit_cpu_alu_with_flags.sv -----
// ---------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags: 8-bit CPU ALU with flags
// Arithmetic, logic, rotate, shift, decimal adjust, carry flag and bit operations.
// ---------------------------------------------------------------------------
// Usage:
//   An input beat is taken on the rising edge where start is high and busy
//   is low. busy is held low, so a beat may be issued in every cycle.
//   The beat is captured in an input register, the operation is evaluated
//   by one pass of combinational logic, and the outcome is captured in a
//   result register.
//   The result leaves from the result register: out_valid is high for
//   exactly one cycle, with out_data holding the result byte, its write
//   enable and the four new flags.
//   Throughput is one beat per cycle, limited only by the single ALU pass
//   between the two registers.
//   The receiver cannot stall; each result beat is taken in its cycle.
//   A synchronous reset clears both valid flags, so no result beat appears
//   for beats in flight at reset.
// ---------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags
  import ebca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic in_valid_r, in_valid_nxt;
  in_t  in_r;
  logic out_valid_r;
  out_t out_r, out_nxt;

  assign busy         = 1'b0;
  assign in_valid_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic       t;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] dif9;
    logic [4:0] dif5;
    logic [7:0] r;
    logic       wr;
    logic       setz;
    logic       z;
    logic       n;
    logic       h;
    logic       c;
    logic [7:0] mask;
    a    = in_r.first_operand;
    b    = in_r.second_operand;
    t    = (in_r.operation == OP_ADC || in_r.operation == OP_SBC) ? in_r.carry_in : 1'b0;
    sum9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
    sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
    dif9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
    dif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
    mask = 8'h01 << in_r.bit_index;
    r    = a;
    wr   = 1'b1;
    setz = 1'b1;
    z    = in_r.zero_in;
    n    = in_r.subtract_in;
    h    = in_r.half_in;
    c    = in_r.carry_in;
    unique case (in_r.operation) inside
      OP_ADD, OP_ADC: begin
        r = sum9[7:0];
        n = 1'b0;
        h = sum5[4];
        c = sum9[8];
      end
      OP_SUB, OP_SBC: begin
        r = dif9[7:0];
        n = 1'b1;
        h = dif5[4];
        c = dif9[8];
      end
      OP_CP: begin
        z    = (dif9[7:0] == 8'd0);
        setz = 1'b0;
        wr   = 1'b0;
        n    = 1'b1;
        h    = dif5[4];
        c    = dif9[8];
      end
      OP_AND: begin
        r = a & b;
        n = 1'b0;
        h = 1'b1;
        c = 1'b0;
      end
      OP_XOR: begin
        r = a ^ b;
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      OP_OR: begin
        r = a | b;
        n = 1'b0;
        h = 1'b0;
        c = 1'b0;
      end
      OP_INC: begin
        r = a + 8'd1;
        n = 1'b0;
        h = (a[3:0] == 4'hf);
      end
      OP_DEC: begin
        r = a - 8'd1;
        n = 1'b1;
        h = (a[3:0] == 4'h0);
      end
      OP_RLCA, OP_RLC: begin
        r = {a[6:0], a[7]};
        c = a[7];
        n = 1'b0;
        h = 1'b0;
      end
      OP_RRCA, OP_RRC: begin
        r = {a[0], a[7:1]};
        c = a[0];
        n = 1'b0;
        h = 1'b0;
      end
      OP_RLA, OP_RL: begin
        r = {a[6:0], in_r.carry_in};
        c = a[7];
        n = 1'b0;
        h = 1'b0;
      end
      OP_RRA, OP_RR: begin
        r = {in_r.carry_in, a[7:1]};
        c = a[0];
        n = 1'b0;
        h = 1'b0;
      end
      OP_DAA: begin
        if (in_r.subtract_in) begin
          r = a - (in_r.carry_in ? DAA_HI_ADJ : 8'd0) - (in_r.half_in ? DAA_LO_ADJ : 8'd0);
        end else begin
          if (in_r.carry_in || a > DAA_HI_MAX) begin
            c = 1'b1;
          end
          r = a + ((in_r.carry_in || a > DAA_HI_MAX) ? DAA_HI_ADJ : 8'd0)
                + ((in_r.half_in || a[3:0] > DAA_LO_MAX) ? DAA_LO_ADJ : 8'd0);
        end
        h = 1'b0;
      end
      OP_CPL: begin
        r    = ~a;
        n    = 1'b1;
        h    = 1'b1;
        setz = 1'b0;
      end
      OP_SCF, OP_CCF: begin
        c    = (in_r.operation == OP_SCF) ? 1'b1 : !in_r.carry_in;
        n    = 1'b0;
        h    = 1'b0;
        wr   = 1'b0;
        setz = 1'b0;
      end
      OP_SLA: begin
        r = {a[6:0], 1'b0};
        c = a[7];
        n = 1'b0;
        h = 1'b0;
      end
      OP_SRA: begin
        r = {a[7], a[7:1]};
        c = a[0];
        n = 1'b0;
        h = 1'b0;
      end
      OP_SWAP: begin
        r = {a[3:0], a[7:4]};
        c = 1'b0;
        n = 1'b0;
        h = 1'b0;
      end
      OP_SRL: begin
        r = {1'b0, a[7:1]};
        c = a[0];
        n = 1'b0;
        h = 1'b0;
      end
      OP_BIT: begin
        z    = !a[in_r.bit_index];
        n    = 1'b0;
        h    = 1'b1;
        wr   = 1'b0;
        setz = 1'b0;
      end
      OP_RES: begin
        r    = a & ~mask;
        setz = 1'b0;
      end
      OP_SET: begin
        r    = a | mask;
        setz = 1'b0;
      end
      default: begin
        wr   = 1'b0;
        setz = 1'b0;
      end
    endcase
    if (setz) begin
      z = (r == 8'd0);
    end
    if (in_r.operation == OP_RLCA || in_r.operation == OP_RRCA ||
        in_r.operation == OP_RLA || in_r.operation == OP_RRA) begin
      z = 1'b0;
    end
    out_nxt.result       = r;
    out_nxt.write_result = wr;
    out_nxt.zero_out     = z;
    out_nxt.subtract_out = n;
    out_nxt.half_out     = h;
    out_nxt.carry_out    = c;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 out_valid)
    else $error("Accepted beat did not produce a result two cycles later.");

  a_no_write_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_result) |-> out_r.result == $past(in_r.first_operand))
    else $error("Result without write enable differs from the first operand.");

  a_rotate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && (in_r.operation == OP_RLCA || in_r.operation == OP_RRCA ||
                    in_r.operation == OP_RLA || in_r.operation == OP_RRA))
    |=> (out_valid && !out_data.zero_out))
    else $error("Accumulator rotate left the zero flag set.");

endmodule
